// ----- rtl/core/sparse_accessor_element_address_top_defines.svh -----
// ----------------------------------------------------------------------------
// Sparse accessor address unit: assertion macros
// Shared property wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SPARSE_ACCESSOR_ELEMENT_ADDRESS_TOP_DEFINES_SVH
`define SPARSE_ACCESSOR_ELEMENT_ADDRESS_TOP_DEFINES_SVH

// Same-cycle implication
`define SAE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sae_pkg.sv -----
// ----------------------------------------------------------------------------
// Sparse accessor address unit: package
// Sizes, codes and the configuration record shared by the configuration block, the top level and the test.
// ----------------------------------------------------------------------------
package sae_pkg;

  localparam int unsigned SparseDepth = 1024;
  localparam int unsigned AddrW       = (SparseDepth > 1) ? $clog2(SparseDepth) : 1;
  localparam int unsigned CntW        = $clog2(SparseDepth + 1);
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned AddrOutW    = 40;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_RSVD   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REJECTED = 2'd1,
    ST_NO_DATA  = 2'd2,
    ST_UNUSED   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    IW_BYTE = 2'd0,
    IW_HALF = 2'd1,
    IW_WORD = 2'd2,
    IW_RSVD = 2'd3
  } idx_width_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ELEMENT_COUNT  = 3'd0,
    REG_SPARSE_LIMIT   = 3'd1,
    REG_INDEX_WIDTH    = 3'd2,
    REG_DENSE_PRESENT  = 3'd3,
    REG_DENSE_BASE     = 3'd4,
    REG_DENSE_STRIDE   = 3'd5,
    REG_SPARSE_BASE    = 3'd6,
    REG_SPARSE_STRIDE  = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_CHECK,
    FSM_MULT,
    FSM_EMIT
  } fsm_e;

  typedef struct packed {
    logic [31:0] element_count;
    logic [10:0] sparse_limit;
    logic [1:0]  index_width;
    logic        dense_present;
    logic [31:0] dense_base;
    logic [7:0]  dense_stride;
    logic [31:0] sparse_values_base;
    logic [7:0]  sparse_value_stride;
  } cfg_t;

endpackage

// ----- rtl/core/sae_ifs.sv -----
// ----------------------------------------------------------------------------
// Sparse accessor address unit: channel interfaces
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface sae_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] raw_index;
  logic [31:0] element_index;

  modport source (output valid, opcode, raw_index, element_index, input ready);
  modport sink   (input valid, opcode, raw_index, element_index, output ready);
endinterface

interface sae_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        from_sparse;
  logic [39:0] byte_address;

  modport source (output valid, status, from_sparse, byte_address, input ready);
  modport sink   (input valid, status, from_sparse, byte_address, output ready);
endinterface

interface sae_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/sae_ram.sv -----
// ----------------------------------------------------------------------------
// Sparse accessor address unit: generic RAM
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sae_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  parameter int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/sae_cfg.sv -----
// ----------------------------------------------------------------------------
// Sparse accessor address unit: configuration registers
// Decodes register writes and holds the eight settings.
// ----------------------------------------------------------------------------
module sae_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  sae_cfg_if.sink       cfg_i,
  output sae_pkg::cfg_t cfg_o
);
  import sae_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_ELEMENT_COUNT: cfg_d.element_count       = cfg_i.data;
        REG_SPARSE_LIMIT:  cfg_d.sparse_limit        = cfg_i.data[10:0];
        REG_INDEX_WIDTH:   cfg_d.index_width         = cfg_i.data[1:0];
        REG_DENSE_PRESENT: cfg_d.dense_present       = cfg_i.data[0];
        REG_DENSE_BASE:    cfg_d.dense_base          = cfg_i.data;
        REG_DENSE_STRIDE:  cfg_d.dense_stride        = cfg_i.data[7:0];
        REG_SPARSE_BASE:   cfg_d.sparse_values_base  = cfg_i.data;
        REG_SPARSE_STRIDE: cfg_d.sparse_value_stride = cfg_i.data[7:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{element_count: 32'd1, sparse_limit: 11'd0, index_width: 2'd0,
                 dense_present: 1'b0, dense_base: 32'd0, dense_stride: 8'd1,
                 sparse_values_base: 32'd0, sparse_value_stride: 8'd1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/sparse_accessor_element_address_top.sv -----
// ----------------------------------------------------------------------------
// Sparse accessor element address unit: top level
// Holds the sorted sparse index table and resolves element byte addresses.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   carries one word per operation: clear, load sparse index, look up.
//   out_o  returns exactly one result word per input word, in order.
//   cfg_i  writes the eight settings; always ready, write only while idle.
// Sequencing (one operation in flight at a time):
//   clear, load and reserved opcodes: the accepted word goes straight to EMIT,
//   where the result enters the output register, then back to IDLE.
//   lookup: S search steps, each a READ then a CHECK, where S is at most
//   ceil(log2(n+1)) for n loaded entries (11 for 1024 entries). Each step is
//   one read of the index RAM plus one compare, so the single RAM port sets
//   the rate; a final READ closes the search, MULT forms the product and EMIT
//   adds the base. The next word is accepted only back in IDLE: in_i.ready
//   is high whenever no operation is in progress, also while a finished
//   result still sits in the output register.
// Reset: the table becomes empty and all settings take their reset values;
//   the RAM contents are not cleared, entries are only read once written.
// Stall: a held result keeps out_o stable; the unit waits with the next
//   result until the output register is taken.
// ----------------------------------------------------------------------------
`include "sparse_accessor_element_address_top_defines.svh"

module sparse_accessor_element_address_top (
  input  logic    clk_i,
  input  logic    rst_ni,
  sae_in_if.sink  in_i,
  sae_out_if.source out_o,
  sae_cfg_if.sink cfg_i
);
  import sae_pkg::*;

  cfg_t cfg;

  fsm_e state_q, state_d;

  logic [CntW-1:0]     count_q, count_d;
  logic [31:0]         last_q;
  logic [CntW-1:0]     lo_q, hi_q;
  logic [CntW-1:0]     mid;
  logic                hit_q;
  logic [31:0]         elem_q;
  status_e             status_q;
  logic [AddrOutW-1:0] prod_q;
  logic [31:0]         base_q;

  logic                out_valid_q;
  status_e             out_status_q;
  logic                out_sparse_q;
  logic [AddrOutW-1:0] out_addr_q;

  logic                in_acc;
  op_e                 op;
  logic [31:0]         masked;
  logic                load_ok;
  logic                ram_we, ram_re;
  logic [AddrW-1:0]    ram_addr;
  logic [31:0]         ram_rdata;
  logic                emit_fire;
  logic [31:0]         mul_idx;
  logic [7:0]          mul_stride;

  sae_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign in_i.ready = (state_q == FSM_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign op         = op_e'(in_i.opcode);

  // mask the raw index and check width code, ordering, bound and room
  always_comb begin
    load_ok = 1'b1;
    unique case (idx_width_e'(cfg.index_width))
      IW_BYTE: masked = {24'd0, in_i.raw_index[7:0]};
      IW_HALF: masked = {16'd0, in_i.raw_index[15:0]};
      IW_WORD: masked = in_i.raw_index;
      default: begin
        masked  = in_i.raw_index;
        load_ok = 1'b0;
      end
    endcase
    if (32'(count_q) >= 32'(cfg.sparse_limit) || 32'(count_q) >= 32'(SparseDepth)) begin
      load_ok = 1'b0;
    end
    if (masked >= cfg.element_count) begin
      load_ok = 1'b0;
    end
    if (count_q != '0 && masked <= last_q) begin
      load_ok = 1'b0;
    end
  end

  // search midpoint; mid < hi <= depth so it fits the RAM address
  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  assign ram_we   = in_acc && (op == OP_LOAD) && load_ok;
  assign ram_re   = (state_q == FSM_READ) && (lo_q < hi_q);
  assign ram_addr = ram_we ? count_q[AddrW-1:0] : mid[AddrW-1:0];

  sae_ram #(
    .Width (32),
    .Depth (SparseDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (masked),
    .rdata_o (ram_rdata)
  );

  assign emit_fire = (state_q == FSM_EMIT) && (!out_valid_q || out_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_acc) begin
          state_d = (op == OP_LOOKUP) ? FSM_READ : FSM_EMIT;
        end
      end
      FSM_READ:  state_d = (lo_q < hi_q) ? FSM_CHECK : FSM_MULT;
      FSM_CHECK: state_d = FSM_READ;
      FSM_MULT:  state_d = FSM_EMIT;
      FSM_EMIT: begin
        if (emit_fire) begin
          state_d = FSM_IDLE;
        end
      end
      default:   state_d = FSM_IDLE;
    endcase
  end

  // entry count update
  always_comb begin
    count_d = count_q;
    if (in_acc && op == OP_CLEAR) begin
      count_d = '0;
    end else if (ram_we) begin
      count_d = count_q + 1'b1;
    end
  end

  // multiplier operand select: override slot or dense element
  assign mul_idx    = hit_q ? 32'(lo_q) : elem_q;
  assign mul_stride = hit_q ? cfg.sparse_value_stride : cfg.dense_stride;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers of the current operation
  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      last_q <= masked;
    end
    unique case (state_q)
      FSM_IDLE: begin
        if (in_acc) begin
          elem_q <= in_i.element_index;
          lo_q   <= '0;
          hi_q   <= count_q;
          hit_q  <= 1'b0;
          prod_q <= '0;
          base_q <= '0;
          if (op == OP_LOAD && !load_ok) begin
            status_q <= ST_REJECTED;
          end else begin
            status_q <= ST_OK;
          end
        end
      end
      FSM_CHECK: begin
        // lower bound step; the last slot that narrows hi is the answer
        if (ram_rdata < elem_q) begin
          lo_q <= mid + 1'b1;
        end else begin
          hi_q  <= mid;
          hit_q <= (ram_rdata == elem_q);
        end
      end
      FSM_MULT: begin
        if (hit_q) begin
          prod_q <= 40'(mul_idx) * 40'(mul_stride);
          base_q <= cfg.sparse_values_base;
        end else if (cfg.dense_present) begin
          prod_q <= 40'(mul_idx) * 40'(mul_stride);
          base_q <= cfg.dense_base;
        end else begin
          prod_q   <= '0;
          base_q   <= '0;
          status_q <= ST_NO_DATA;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_status_q <= status_q;
      out_sparse_q <= hit_q;
      out_addr_q   <= 40'(base_q) + prod_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.from_sparse  = out_sparse_q;
  assign out_o.byte_address = out_addr_q;

  // assertions
  `SAE_ASSERT_NOW(a_count_in_range, 1'b1, 32'(count_q) <= 32'(SparseDepth),
                  "entry count exceeds table depth")
  `SAE_ASSERT_NOW(a_search_window, state_q == FSM_READ || state_q == FSM_CHECK,
                  lo_q <= hi_q && hi_q <= count_q, "search window out of order")
  `SAE_ASSERT_NEXT(a_write_counts, ram_we, count_q == $past(count_q) + 1'b1,
                   "table write without count advance")
  `SAE_ASSERT_NOW(a_hit_in_table, state_q == FSM_MULT && hit_q, lo_q < count_q,
                  "hit slot beyond loaded entries")

endmodule

// ----- verif/sparse_accessor_element_address_top_test.sv -----
// ----------------------------------------------------------------------------
// Sparse accessor element address unit: block-level test
// Drives clear, load and lookup words through the valid/ready channels and
// programs the eight settings between phases. A tracker class mirrors the
// sorted index table and predicts every result word: status, sparse hit and
// byte address. Both channel sides stall at random, except for a few phases
// that run with no gaps at all.
// ----------------------------------------------------------------------------
module sparse_accessor_element_address_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sae_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned NumPhases  = 14;

  typedef struct packed {
    status_e     status;
    logic        from_sparse;
    logic [39:0] byte_address;
  } result_t;

  // Mirror of the index table and settings; queues one result per input word
  class sparse_lookup_tracker;
    cfg_t        settings;
    logic [31:0] slots [SparseDepth];
    int unsigned loaded;
    result_t     expected_words [$];
    int unsigned mismatches;

    function new();
      settings.element_count       = 32'd1;
      settings.sparse_limit        = 11'd0;
      settings.index_width         = IW_BYTE;
      settings.dense_present       = 1'b0;
      settings.dense_base          = 32'd0;
      settings.dense_stride        = 8'd1;
      settings.sparse_values_base  = 32'd0;
      settings.sparse_value_stride = 8'd1;
      loaded     = 0;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] d);
      case (idx)
        REG_ELEMENT_COUNT: settings.element_count       = d;
        REG_SPARSE_LIMIT:  settings.sparse_limit        = d[10:0];
        REG_INDEX_WIDTH:   settings.index_width         = d[1:0];
        REG_DENSE_PRESENT: settings.dense_present       = d[0];
        REG_DENSE_BASE:    settings.dense_base          = d;
        REG_DENSE_STRIDE:  settings.dense_stride        = d[7:0];
        REG_SPARSE_BASE:   settings.sparse_values_base  = d;
        REG_SPARSE_STRIDE: settings.sparse_value_stride = d[7:0];
        default: ;
      endcase
    endfunction

    // Append a masked index if it is in range, ascending and there is room
    function status_e load_index(logic [31:0] raw);
      int unsigned room;
      logic [31:0] v;
      room = (settings.sparse_limit < SparseDepth) ? settings.sparse_limit : SparseDepth;
      case (idx_width_e'(settings.index_width))
        IW_BYTE: v = {24'd0, raw[7:0]};
        IW_HALF: v = {16'd0, raw[15:0]};
        IW_WORD: v = raw;
        default: return ST_REJECTED;
      endcase
      if (loaded >= room || v >= settings.element_count ||
          (loaded != 0 && v <= slots[loaded-1]))
        return ST_REJECTED;
      slots[loaded] = v;
      loaded++;
      return ST_OK;
    endfunction

    // Lower-bound search; sparse hit, else dense address or no data
    function result_t locate_element(logic [31:0] elem);
      int unsigned lo, hi, mid;
      result_t r;
      lo = 0;
      hi = loaded;
      r.status       = ST_OK;
      r.from_sparse  = 1'b0;
      r.byte_address = '0;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (slots[mid] < elem) lo = mid + 1;
        else hi = mid;
      end
      if (lo < loaded && slots[lo] == elem) begin
        r.from_sparse  = 1'b1;
        r.byte_address = 40'(settings.sparse_values_base) +
                         40'(lo) * 40'(settings.sparse_value_stride);
      end else if (settings.dense_present) begin
        r.byte_address = 40'(settings.dense_base) + 40'(elem) * 40'(settings.dense_stride);
      end else begin
        r.status = ST_NO_DATA;
      end
      return r;
    endfunction

    function void note_input(op_e op, logic [31:0] raw, logic [31:0] elem);
      result_t r;
      r.status       = ST_OK;
      r.from_sparse  = 1'b0;
      r.byte_address = '0;
      case (op)
        OP_CLEAR:  loaded = 0;
        OP_LOAD:   r.status = load_index(raw);
        OP_LOOKUP: r = locate_element(elem);
        default: ;
      endcase
      expected_words.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: status %0d sparse %0b addr %h",
                   got.status, got.from_sparse, got.byte_address);
        return;
      end
      want = expected_words.pop_front();
      if (got.status !== want.status || got.from_sparse !== want.from_sparse ||
          got.byte_address !== want.byte_address) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d sparse %0b addr %h, got status %0d sparse %0b addr %h",
                   want.status, want.from_sparse, want.byte_address,
                   got.status, got.from_sparse, got.byte_address);
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   steady;
  int unsigned quiet_cycles;
  sparse_lookup_tracker sb;

  sae_in_if  in_if ();
  sae_out_if out_if ();
  sae_cfg_if cfg_if ();

  sparse_accessor_element_address_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < 25);
  endfunction

  function automatic longint unsigned width_mask(logic [1:0] w);
    case (idx_width_e'(w))
      IW_BYTE: return 64'hFF;
      IW_HALF: return 64'hFFFF;
      default: return 64'hFFFF_FFFF;
    endcase
  endfunction

  // Mostly ascending in-range indices, with some duplicates and junk
  function automatic logic [31:0] pick_load_raw();
    longint unsigned mask, bound, v, last;
    mask  = width_mask(sb.settings.index_width);
    bound = sb.settings.element_count;
    if (bound > mask + 1) bound = mask + 1;
    last = (sb.loaded != 0) ? sb.slots[sb.loaded-1] : 0;
    if ($urandom_range(0, 99) < 72) begin
      v = (sb.loaded != 0) ? last + 1 : 0;
      case ($urandom_range(0, 3))
        0: ;
        1, 2: v += $urandom_range(0, 3);
        default: v += $urandom_range(0, 5000);
      endcase
      if (v >= bound) v = (sb.loaded != 0) ? last + 1 : 0;
    end else begin
      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = last;
        2: v = sb.settings.element_count;
        default: v = last - 1;
      endcase
    end
    return 32'(v & mask) | ($urandom & ~32'(mask));
  endfunction

  // Stored entries, their neighbors, and values anywhere
  function automatic logic [31:0] pick_lookup_index();
    int unsigned roll;
    logic [31:0] hit;
    roll = $urandom_range(0, 99);
    if (sb.loaded != 0) hit = sb.slots[$urandom_range(0, sb.loaded - 1)];
    if (sb.loaded != 0 && roll < 50) return hit;
    if (sb.loaded != 0 && roll < 70) return $urandom_range(0, 1) ? hit + 1 : hit - 1;
    if (roll < 88) return $urandom_range(0, 32'(width_mask(sb.settings.index_width)));
    return $urandom;
  endfunction

  task automatic send_word(op_e op, logic [31:0] raw, logic [31:0] elem);
    @(negedge clk_i);
    while (take_break()) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid         = 1'b1;
    in_if.opcode        = op;
    in_if.raw_index     = raw;
    in_if.element_index = elem;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_input(op, raw, elem);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] d);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = d;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.set_reg(idx, d);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic program_settings(cfg_t s);
    write_reg(REG_ELEMENT_COUNT, s.element_count);
    write_reg(REG_SPARSE_LIMIT,  32'(s.sparse_limit));
    write_reg(REG_INDEX_WIDTH,   32'(s.index_width));
    write_reg(REG_DENSE_PRESENT, 32'(s.dense_present));
    write_reg(REG_DENSE_BASE,    s.dense_base);
    write_reg(REG_DENSE_STRIDE,  32'(s.dense_stride));
    write_reg(REG_SPARSE_BASE,   s.sparse_values_base);
    write_reg(REG_SPARSE_STRIDE, 32'(s.sparse_value_stride));
  endtask

  // Drop valid and let every outstanding result drain
  task automatic settle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_random_settings();
    cfg_t s;
    case ($urandom_range(0, 4))
      0: s.element_count = 32'd1;
      1: s.element_count = 32'hFFFF_FFFF;
      2: s.element_count = $urandom_range(2, 300);
      3: s.element_count = $urandom_range(256, 70000);
      default: s.element_count = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0: s.sparse_limit = 11'd0;
      1: s.sparse_limit = 11'd1;
      2: s.sparse_limit = 11'd1024;
      3: s.sparse_limit = 11'd2047;
      default: s.sparse_limit = 11'($urandom_range(2, 48));
    endcase
    s.index_width   = ($urandom_range(0, 9) == 0) ? IW_RSVD : 2'($urandom_range(0, 2));
    s.dense_present = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: s.dense_base = 32'd0;
      1: s.dense_base = 32'hFFFF_FFFF;
      default: s.dense_base = $urandom;
    endcase
    s.sparse_values_base  = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom;
    s.dense_stride        = $urandom_range(0, 4) == 0 ? 8'd255 : 8'($urandom_range(1, 255));
    s.sparse_value_stride = $urandom_range(0, 4) == 0 ? 8'd1 : 8'($urandom_range(1, 255));
    program_settings(s);
  endtask

  // Result side: random stalls, check every accepted word
  always @(negedge clk_i) begin
    out_if.ready = !take_break();
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.status       = status_e'(out_if.status);
      got.from_sparse  = out_if.from_sparse;
      got.byte_address = out_if.byte_address;
      sb.check_result(got);
    end
  end

  // Watchdog on cycles with no handshake on any channel
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no handshake for %0d cycles", QuietLimit);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    cfg_t s;
    int unsigned n, roll;
    sb                  = new();
    steady              = 1'b0;
    quiet_cycles        = 0;
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.opcode        = OP_CLEAR;
    in_if.raw_index     = '0;
    in_if.element_index = '0;
    out_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = REG_ELEMENT_COUNT;
    cfg_if.data         = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: no room in the table, no dense buffer
    send_word(OP_LOAD, 32'd0, 32'd0);
    send_word(OP_LOOKUP, 32'd0, 32'd0);
    send_word(OP_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_CLEAR, 32'd0, 32'd0);
    settle();

    // Word indices, largest bases and strides, four slots
    s.element_count       = 32'hFFFF_FFFF;
    s.sparse_limit        = 11'd4;
    s.index_width         = IW_WORD;
    s.dense_present       = 1'b1;
    s.dense_base          = 32'hFFFF_FFFF;
    s.dense_stride        = 8'd255;
    s.sparse_values_base  = 32'hFFFF_FFFF;
    s.sparse_value_stride = 8'd255;
    program_settings(s);
    send_word(OP_LOAD, 32'd0, 32'd0);
    send_word(OP_LOAD, 32'd0, 32'd0);              // not above last entry
    send_word(OP_LOAD, 32'd5, 32'd0);
    send_word(OP_LOAD, 32'd1000, 32'd0);
    send_word(OP_LOAD, 32'hFFFF_FFFE, 32'd0);
    send_word(OP_LOAD, 32'hFFFF_FFFF, 32'd0);      // table full, out of range
    send_word(OP_LOOKUP, 32'd0, 32'd0);
    send_word(OP_LOOKUP, 32'd0, 32'hFFFF_FFFE);
    send_word(OP_LOOKUP, 32'd0, 32'hFFFF_FFFF);    // largest dense address
    send_word(OP_LOOKUP, 32'd0, 32'd6);
    send_word(OP_LOOKUP, 32'd0, 32'd1000);
    send_word(OP_CLEAR, 32'd0, 32'd0);
    send_word(OP_LOOKUP, 32'd0, 32'd5);
    settle();

    // Byte indices, limit past the depth, zero strides, no dense buffer
    s.element_count       = 32'd300;
    s.sparse_limit        = 11'd2047;
    s.index_width         = IW_BYTE;
    s.dense_present       = 1'b0;
    s.dense_base          = 32'd0;
    s.dense_stride        = 8'd0;
    s.sparse_values_base  = 32'h0000_1000;
    s.sparse_value_stride = 8'd0;
    program_settings(s);
    send_word(OP_LOAD, 32'h1234_5605, 32'd0);
    send_word(OP_LOAD, 32'h0000_0105, 32'd0);      // masks to a duplicate
    send_word(OP_LOAD, 32'hFFFF_FFFF, 32'd0);
    send_word(OP_LOOKUP, 32'd0, 32'd255);
    send_word(OP_LOOKUP, 32'd0, 32'd7);
    settle();

    // Halfword mask, then the reserved width rejects everything
    write_reg(REG_ELEMENT_COUNT, 32'h0001_0000);
    write_reg(REG_INDEX_WIDTH, 32'(IW_HALF));
    send_word(OP_LOAD, 32'hABCD_1000, 32'd0);
    settle();
    write_reg(REG_INDEX_WIDTH, 32'(IW_RSVD));
    send_word(OP_LOAD, 32'h0000_2000, 32'd0);
    send_word(OP_LOOKUP, 32'd0, 32'h0000_1000);
    settle();

    // Random phases: mostly ascending loads mixed with lookups
    for (int p = 0; p < NumPhases; p++) begin
      steady = (p == 4 || p == 5);
      apply_random_settings();
      if ($urandom_range(0, 3) != 0) send_word(OP_CLEAR, $urandom, $urandom);
      n = $urandom_range(45, 75);
      repeat (n) begin
        roll = $urandom_range(0, 99);
        if (roll < 3)       send_word(OP_CLEAR, $urandom, $urandom);
        else if (roll < 5)  send_word(OP_RSVD, $urandom, $urandom);
        else if (roll < 52) send_word(OP_LOAD, pick_load_raw(), $urandom);
        else                send_word(OP_LOOKUP, $urandom, pick_lookup_index());
      end
      settle();
    end
    steady = 1'b0;

    repeat (36) @(posedge clk_i);
    if (sb.pending() != 0) sb.mismatches++;
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/sae_pkg.sv
rtl/core/sae_ifs.sv
rtl/core/sae_ram.sv
rtl/core/sae_cfg.sv
rtl/core/sparse_accessor_element_address_top.sv
verif/sparse_accessor_element_address_top_test.sv
